>>> design/mtv_pkg.sv
// shared types and constants of the media type validator
package mtv_pkg;

  localparam int unsigned ByteW = 8;

  // bytes below this limit are control bytes, not allowed in a quoted string
  localparam logic [ByteW-1:0] CtrlLimit = 8'h20;

  localparam logic [ByteW-1:0] ChSlash  = 8'h2f;
  localparam logic [ByteW-1:0] ChSemi   = 8'h3b;
  localparam logic [ByteW-1:0] ChEqual  = 8'h3d;
  localparam logic [ByteW-1:0] ChDquote = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5c;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChNul    = 8'h00;

  // grammar position, one-hot
  typedef enum logic [10:0] {
    PhTypeFirst = 11'b000_0000_0001,
    PhType      = 11'b000_0000_0010,
    PhSubFirst  = 11'b000_0000_0100,
    PhSub       = 11'b000_0000_1000,
    PhParamLead = 11'b000_0001_0000,
    PhKey       = 11'b000_0010_0000,
    PhValFirst  = 11'b000_0100_0000,
    PhQuoted    = 11'b000_1000_0000,
    PhTokVal    = 11'b001_0000_0000,
    PhAfterVal  = 11'b010_0000_0000,
    PhFail      = 11'b100_0000_0000
  } phase_e;

  // character classes of one byte
  typedef struct packed {
    logic tchar;
    logic blank;
    logic slash;
    logic semi;
    logic equal;
    logic dquote;
    logic qbad;
    logic nul;
  } char_class_t;

endpackage

>>> design/mtv_classify.sv
// byte classifier: token, blank and delimiter classes of one byte
module mtv_classify (
  input  logic [mtv_pkg::ByteW-1:0] byte_i,
  output mtv_pkg::char_class_t      class_o
);
  import mtv_pkg::*;

  logic is_alpha;
  logic is_digit;
  logic is_sym;

  assign is_alpha = (byte_i >= 8'h41 && byte_i <= 8'h5a) ||
                    (byte_i >= 8'h61 && byte_i <= 8'h7a);
  assign is_digit = byte_i >= 8'h30 && byte_i <= 8'h39;

  // the tchar symbols ! # $ % & ' * + - . ^ _ ` | ~
  always_comb begin
    unique case (byte_i)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
      8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: is_sym = 1'b1;
      default: is_sym = 1'b0;
    endcase
  end

  assign class_o.tchar  = is_alpha || is_digit || is_sym;
  assign class_o.blank  = byte_i == ChSpace || byte_i == ChTab;
  assign class_o.slash  = byte_i == ChSlash;
  assign class_o.semi   = byte_i == ChSemi;
  assign class_o.equal  = byte_i == ChEqual;
  assign class_o.dquote = byte_i == ChDquote;
  assign class_o.qbad   = byte_i < CtrlLimit || byte_i == ChBslash;
  assign class_o.nul    = byte_i == ChNul;

endmodule

>>> design/mtv_parser.sv
// grammar state machine: phase and terminator registers, verdict logic
module mtv_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 has_byte_i,
  input  logic                 last_i,
  input  mtv_pkg::char_class_t class_i,
  output logic                 verdict_o
);
  import mtv_pkg::*;

  phase_e phase_q, phase_d, phase_adv;
  logic   term_q, term_d;

  always_comb begin
    phase_adv = PhFail;
    unique case (phase_q)
      PhTypeFirst: phase_adv = class_i.tchar ? PhType : PhFail;
      PhType: begin
        if (class_i.tchar)      phase_adv = PhType;
        else if (class_i.slash) phase_adv = PhSubFirst;
      end
      PhSubFirst: phase_adv = class_i.tchar ? PhSub : PhFail;
      PhSub: begin
        if (class_i.tchar)     phase_adv = PhSub;
        else if (class_i.semi) phase_adv = PhParamLead;
      end
      PhParamLead: begin
        if (class_i.blank)      phase_adv = PhParamLead;
        else if (class_i.tchar) phase_adv = PhKey;
      end
      PhKey: begin
        if (class_i.tchar)      phase_adv = PhKey;
        else if (class_i.equal) phase_adv = PhValFirst;
      end
      PhValFirst: begin
        if (class_i.dquote)     phase_adv = PhQuoted;
        else if (class_i.tchar) phase_adv = PhTokVal;
      end
      PhQuoted: begin
        if (class_i.dquote)     phase_adv = PhAfterVal;
        else if (!class_i.qbad) phase_adv = PhQuoted;
      end
      PhTokVal: begin
        if (class_i.tchar)      phase_adv = PhTokVal;
        else if (class_i.blank) phase_adv = PhAfterVal;
        else if (class_i.semi)  phase_adv = PhParamLead;
      end
      PhAfterVal: begin
        if (class_i.blank)     phase_adv = PhAfterVal;
        else if (class_i.semi) phase_adv = PhParamLead;
      end
      default: phase_adv = PhFail;
    endcase
  end

  // a missing or zero byte ends the string; later bytes are ignored
  always_comb begin
    phase_d = phase_q;
    term_d  = term_q;
    if (!term_q) begin
      if (!has_byte_i || class_i.nul) term_d  = 1'b1;
      else                            phase_d = phase_adv;
    end
  end

  assign verdict_o = phase_d == PhSub || phase_d == PhTokVal || phase_d == PhAfterVal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTypeFirst;
      term_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PhTypeFirst;
        term_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        term_q  <= term_d;
      end
    end
  end

endmodule

>>> design/media_type_validator.sv
// top level of the media type validator: input register, parser, result register
//
// Checks a media-type string (type/subtype with optional ;key=value parameters)
// delivered one byte per input transaction. A transaction carries char_byte_i,
// has_byte_i and last_i; a zero byte or has_byte_i low ends the string and the
// rest up to last_i is ignored. Only the transaction with last_i high yields a
// result transaction, carrying valid_res_o (1 for a well-formed media type).
// Both channels use valid and stall: a transaction moves when valid is high and
// stall is low.
// A final byte is accepted into the input register and is then parsed into the
// result register, once the result register is free. Throughput: one byte per
// cycle while in_stall_o is low; the input register and the grammar state
// machine step together.
// When the receiver stalls, the result is held and bytes that produce no result
// keep flowing; only a second final byte waits, and in_stall_o then goes high.
// Reset clears both valid flags and returns the parser to the first type byte.
module media_type_validator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [mtv_pkg::ByteW-1:0] char_byte_i,
  input  logic                      has_byte_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      valid_res_o
);
  import mtv_pkg::*;

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_has_q;
  logic             s1_last_q;
  logic             out_free;
  logic             s1_fire;
  logic             in_fire;
  logic             res_q;
  logic             verdict;
  char_class_t      char_class;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= char_byte_i;
      s1_has_q  <= has_byte_i;
      s1_last_q <= last_i;
    end
  end

  mtv_classify u_classify (
    .byte_i  (s1_byte_q),
    .class_o (char_class)
  );

  mtv_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_fire),
    .has_byte_i (s1_has_q),
    .last_i     (s1_last_q),
    .class_i    (char_class),
    .verdict_o  (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_fire && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      res_q <= verdict;
    end
  end

  assign valid_res_o = res_q;

  // stall only backs up behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked final transaction");

  // a new result only follows a final transaction leaving the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_fire && s1_last_q))
    else $error("result appeared without a final transaction");

  // a held result is not overwritten while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_q))
    else $error("stalled result lost or changed");

endmodule

>>> verif/testbench.sv
// testbench of the media type validator: directed and random strings checked by a grammar predictor
module testbench;
  import mtv_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             has;
    logic             fin;
  } str_item_t;

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned TargetBytes = 900;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned NumSyms     = 15;

  // tchar symbols: ! # $ % & ' * + - . ^ _ ` | ~
  localparam logic [NumSyms*ByteW-1:0] TokenSyms = {
    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
    8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] char_byte_i = '0;
  logic             has_byte_i  = 1'b0;
  logic             last_i      = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             valid_res_o;

  media_type_validator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_byte_i(char_byte_i),
    .has_byte_i (has_byte_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .valid_res_o(valid_res_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  str_item_t   byte_q[$];     // transactions waiting to be driven
  str_item_t   str_buf[$];    // string under construction
  str_item_t   cur_item;
  logic        verdict_q[$];  // expected verdicts, oldest first
  logic        want_verdict;

  phase_e      cur_phase   = PhTypeFirst;
  bit          str_ended   = 1'b0;

  int unsigned total_bytes = 0;
  int unsigned bytes_taken = 0;
  int unsigned strings_built = 0;
  int unsigned verdicts_due = 0;
  int unsigned verdicts_popped = 0;
  int unsigned valid_due = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  // ---------------------------------------------------------------- grammar predictor

  function automatic bit is_token_byte(logic [ByteW-1:0] b);
    if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
        (b >= 8'h30 && b <= 8'h39)) return 1'b1;
    for (int i = 0; i < NumSyms; i++) begin
      if (TokenSyms[i*ByteW +: ByteW] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_blank(logic [ByteW-1:0] b);
    return b == ChSpace || b == ChTab;
  endfunction

  function automatic phase_e next_phase(phase_e ph, logic [ByteW-1:0] b);
    case (ph)
      PhTypeFirst: begin
        if (is_token_byte(b)) return PhType;
      end
      PhType: begin
        if (is_token_byte(b)) return PhType;
        if (b == ChSlash) return PhSubFirst;
      end
      PhSubFirst: begin
        if (is_token_byte(b)) return PhSub;
      end
      PhSub: begin
        if (is_token_byte(b)) return PhSub;
        if (b == ChSemi) return PhParamLead;
      end
      PhParamLead: begin
        if (is_blank(b)) return PhParamLead;
        if (is_token_byte(b)) return PhKey;
      end
      PhKey: begin
        if (is_token_byte(b)) return PhKey;
        if (b == ChEqual) return PhValFirst;
      end
      PhValFirst: begin
        if (b == ChDquote) return PhQuoted;
        if (is_token_byte(b)) return PhTokVal;
      end
      PhQuoted: begin
        if (b == ChDquote) return PhAfterVal;
        if (b >= CtrlLimit && b != ChBslash) return PhQuoted;
      end
      PhTokVal: begin
        if (is_token_byte(b)) return PhTokVal;
        if (is_blank(b)) return PhAfterVal;
        if (b == ChSemi) return PhParamLead;
      end
      PhAfterVal: begin
        if (is_blank(b)) return PhAfterVal;
        if (b == ChSemi) return PhParamLead;
      end
      default: ;
    endcase
    return PhFail;
  endfunction

  task automatic take_byte(str_item_t it);
    logic ok;
    // a zero byte or a missing byte ends the string, the rest is ignored
    if (!str_ended) begin
      if (!it.has || it.ch == ChNul) str_ended = 1'b1;
      else cur_phase = next_phase(cur_phase, it.ch);
    end
    bytes_taken++;
    if (it.fin) begin
      ok = (cur_phase == PhSub) || (cur_phase == PhTokVal) || (cur_phase == PhAfterVal);
      verdict_q.push_back(ok);
      verdicts_due++;
      if (ok) valid_due++;
      cur_phase = PhTypeFirst;
      str_ended = 1'b0;
    end
  endtask

  task automatic flag_error(string msg);
    error_cnt++;
    if (error_cnt <= MaxReports) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  // ---------------------------------------------------------------- string generation

  function automatic logic [ByteW-1:0] rand_token_byte();
    int unsigned k;
    k = $urandom_range(3);
    case (k)
      0: return 8'h41 + ByteW'($urandom_range(25));
      1: return 8'h61 + ByteW'($urandom_range(25));
      2: return 8'h30 + ByteW'($urandom_range(9));
      default: begin
        k = $urandom_range(NumSyms - 1);
        return TokenSyms[k*ByteW +: ByteW];
      end
    endcase
  endfunction

  function automatic logic [ByteW-1:0] rand_blank();
    return $urandom_range(1) ? ChSpace : ChTab;
  endfunction

  function automatic logic [ByteW-1:0] rand_quoted_byte();
    logic [ByteW-1:0] b;
    // now and then a byte that is not allowed inside quotes
    if ($urandom_range(19) == 0)
      return $urandom_range(1) ? ChBslash : ByteW'($urandom_range(1, 8'h1f));
    do b = ByteW'($urandom_range(8'h20, 8'hff));
    while (b == ChDquote || b == ChBslash);
    return b;
  endfunction

  task automatic add_item(logic [ByteW-1:0] b, logic has);
    str_item_t it;
    it.ch  = b;
    it.has = has;
    it.fin = 1'b0;
    str_buf.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b1);
  endtask

  task automatic add_token();
    repeat ($urandom_range(1, 4)) add_item(rand_token_byte(), 1'b1);
  endtask

  task automatic flush_string();
    str_item_t it;
    if (str_buf.size() == 0) begin
      // empty string: either a lone missing byte or a lone zero byte
      it.has = 1'($urandom_range(1));
      it.ch  = it.has ? ChNul : ByteW'($urandom_range(255));
    end else begin
      it = str_buf.pop_back();
    end
    it.fin = 1'b1;
    str_buf.push_back(it);
    while (str_buf.size() != 0) byte_q.push_back(str_buf.pop_front());
    strings_built++;
  endtask

  task automatic add_random_string();
    int unsigned style;
    int unsigned pos;
    str_item_t   it;
    style = $urandom_range(99);
    if (style < 6) begin
      repeat ($urandom_range(1, 6))
        add_item(ByteW'($urandom_range(255)), $urandom_range(9) != 0);
    end else begin
      add_token();
      add_item(ChSlash, 1'b1);
      add_token();
      repeat ($urandom_range(0, 3)) begin
        add_item(ChSemi, 1'b1);
        repeat ($urandom_range(0, 2)) add_item(rand_blank(), 1'b1);
        add_token();
        add_item(ChEqual, 1'b1);
        if ($urandom_range(1)) begin
          add_item(ChDquote, 1'b1);
          repeat ($urandom_range(0, 4)) add_item(rand_quoted_byte(), 1'b1);
          add_item(ChDquote, 1'b1);
        end else begin
          add_token();
        end
        if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) add_item(rand_blank(), 1'b1);
      end
      if (style < 18) begin
        // one byte overwritten
        pos = $urandom_range(str_buf.size() - 1);
        it = str_buf[pos];
        it.ch = ByteW'($urandom_range(255));
        str_buf[pos] = it;
      end else if (style < 26) begin
        // cut short, possibly down to nothing
        pos = $urandom_range(str_buf.size() - 1);
        while (str_buf.size() > pos) void'(str_buf.pop_back());
      end else if (style < 36) begin
        // early end of string followed by garbage
        pos = $urandom_range(str_buf.size());
        it.has = 1'($urandom_range(1));
        it.ch  = it.has ? ChNul : ByteW'($urandom_range(255));
        it.fin = 1'b0;
        str_buf.insert(pos, it);
        repeat ($urandom_range(0, 3))
          add_item(ByteW'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    flush_string();
  endtask

  // ---------------------------------------------------------------- idling

  function automatic int unsigned idle_pct(bit receiver);
    int unsigned stage;
    stage = (total_bytes == 0) ? 0 : bytes_taken * 3 / total_bytes;
    case (stage)
      0: return receiver ? 55 : 23;
      1: return receiver ? 23 : 55;
      default: return 0;
    endcase
  endfunction

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) take_byte(cur_item);
      // a stalled transaction keeps its payload
      if (!in_valid_i || !in_stall_o) begin
        if (byte_q.size() != 0 && !roll(idle_pct(1'b0))) begin
          cur_item = byte_q.pop_front();
          in_valid_i  <= 1'b1;
          char_byte_i <= cur_item.ch;
          has_byte_i  <= cur_item.has;
          last_i      <= cur_item.fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected verdict %b", valid_res_o));
        end else begin
          want_verdict = verdict_q.pop_front();
          verdicts_popped++;
          if (valid_res_o !== want_verdict)
            flag_error($sformatf("verdict expected %b, got %b", want_verdict, valid_res_o));
        end
      end
      out_stall_i <= roll(idle_pct(1'b1));
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d bytes taken, %0d verdicts outstanding",
               cycle_cnt, bytes_taken, total_bytes, verdicts_due - verdicts_popped);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus and end of run

  initial begin
    add_text("a/b");
    flush_string();
    add_item(ByteW'($urandom_range(255)), 1'b0);
    flush_string();
    add_text("x/y");
    add_item(ChNul, 1'b1);
    add_item(8'hff, 1'b1);
    flush_string();
    add_item(8'hff, 1'b1);
    flush_string();
    add_text("a/b");
    add_item(8'h5a, 1'b0);
    add_item(8'h40, 1'b1);
    flush_string();
    add_item(ChNul, 1'b1);
    flush_string();
    add_text("t/s;k=\"");
    add_item(8'h7f, 1'b1);
    add_item(ChDquote, 1'b1);
    add_item(ChTab, 1'b1);
    flush_string();
    while (byte_q.size() < TargetBytes) add_random_string();
    total_bytes = byte_q.size();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (bytes_taken == total_bytes);
    wait (verdicts_popped == verdicts_due);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d strings in %0d byte transactions across three idle profiles",
             strings_built, total_bytes);
    $display("checked %0d verdicts (%0d valid), %0d mismatches",
             verdicts_popped, valid_due, error_cnt);
    if (error_cnt == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mtv_pkg.sv
design/mtv_classify.sv
design/mtv_parser.sv
design/media_type_validator.sv
verif/testbench.sv
